// File: rtl/core/rtte_pkg.sv
// ----------------------------------------------------------------------------
// rtte_pkg
// Shared types and constants for the round-trip time estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtte_pkg;

    localparam int WEIGHT_W  = 17;
    localparam int FIELD_W   = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SAT_W     = 64;

    // deviation scale for the timeout is 4, a shift by two
    localparam int DEV_SHIFT = 2;

    localparam logic [WEIGHT_W-1:0] Q_ONE = WEIGHT_W'(65536);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WEIGHT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_KEEP_WEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_CEILING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE = 3'd4;

    // reset values of the configuration registers
    localparam logic [WEIGHT_W-1:0] RST_SAMPLE_WEIGHT    = WEIGHT_W'(8192);
    localparam logic [WEIGHT_W-1:0] RST_DEV_KEEP_WEIGHT  = WEIGHT_W'(49152);
    localparam logic [FIELD_W-1:0]  RST_TIMEOUT_FLOOR    = 32'd200000;
    localparam logic [FIELD_W-1:0]  RST_TIMEOUT_CEILING  = 32'd60000000;
    localparam logic [FIELD_W-1:0]  RST_INITIAL_ESTIMATE = 32'd1000000;

    typedef struct packed {
        logic [WEIGHT_W-1:0] sample_weight;
        logic [WEIGHT_W-1:0] deviation_keep_weight;
        logic [FIELD_W-1:0]  timeout_floor;
        logic [FIELD_W-1:0]  timeout_ceiling;
        logic [FIELD_W-1:0]  initial_estimate;
    } rtte_cfg_t;

    // clamp a value to the largest value of a given bit width
    function automatic logic [SAT_W-1:0] sat_time(logic [SAT_W-1:0] v, int unsigned w);
        logic [SAT_W-1:0] max_v;
        max_v = (w >= SAT_W) ? {SAT_W{1'b1}} : ((SAT_W'(1) << w) - SAT_W'(1));
        return (v > max_v) ? max_v : v;
    endfunction

    function automatic logic [WEIGHT_W-1:0] sat_weight(logic [WEIGHT_W-1:0] w);
        return (w > Q_ONE) ? Q_ONE : w;
    endfunction

endpackage

// File: rtl/core/rtt_estimator_rto.sv
// ----------------------------------------------------------------------------
// rtt_estimator_rto
// Path: an accepted sample is held in the input register, then the update writes the result register.
// Throughput: one sample per cycle while the output is taken; the update is a single registered pass.
// Reset: registers load their defaults, the estimate takes the initial estimate
// and the deviation clears. Writing initial_estimate restarts the same way.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtt_estimator_rto
    import rtte_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] rtt_sample

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [95:0]          m_axis_tdata    // [31:0] smoothed_rtt,
                                                 // [63:32] rtt_deviation,
                                                 // [95:64] retrans_timeout
);

    localparam logic [TIME_WIDTH-1:0] INIT_RST_TIME =
        TIME_WIDTH'(sat_time(SAT_W'(RST_INITIAL_ESTIMATE), TIME_WIDTH));

    rtte_cfg_t             cfg_reg;
    logic                  in_valid_reg;
    logic [FIELD_W-1:0]    sample_reg;
    logic [TIME_WIDTH-1:0] estimate_reg;
    logic [TIME_WIDTH-1:0] deviation_reg;
    logic                  out_valid_reg;
    logic [FIELD_W-1:0]    out_estimate_reg;
    logic [FIELD_W-1:0]    out_deviation_reg;
    logic [FIELD_W-1:0]    out_timeout_reg;

    logic [TIME_WIDTH-1:0] new_estimate;
    logic [TIME_WIDTH-1:0] new_deviation;
    logic [TIME_WIDTH-1:0] new_timeout;
    logic [TIME_WIDTH-1:0] restart_time;
    logic                  advance;
    logic                  restart;

    rtte_update #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_update (
        .rtt_sample    (sample_reg),
        .estimate      (estimate_reg),
        .deviation     (deviation_reg),
        .cfg           (cfg_reg),
        .new_estimate  (new_estimate),
        .new_deviation (new_deviation),
        .new_timeout   (new_timeout)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign restart       = cfg_wr_en && (cfg_index == REG_INITIAL_ESTIMATE);
    assign restart_time  = TIME_WIDTH'(sat_time(SAT_W'(cfg_data), TIME_WIDTH));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_timeout_reg, out_deviation_reg, out_estimate_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_weight         <= RST_SAMPLE_WEIGHT;
            cfg_reg.deviation_keep_weight <= RST_DEV_KEEP_WEIGHT;
            cfg_reg.timeout_floor         <= RST_TIMEOUT_FLOOR;
            cfg_reg.timeout_ceiling       <= RST_TIMEOUT_CEILING;
            cfg_reg.initial_estimate      <= RST_INITIAL_ESTIMATE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SAMPLE_WEIGHT:    cfg_reg.sample_weight         <= cfg_data[WEIGHT_W-1:0];
                REG_DEV_KEEP_WEIGHT:  cfg_reg.deviation_keep_weight <= cfg_data[WEIGHT_W-1:0];
                REG_TIMEOUT_FLOOR:    cfg_reg.timeout_floor         <= cfg_data;
                REG_TIMEOUT_CEILING:  cfg_reg.timeout_ceiling       <= cfg_data;
                REG_INITIAL_ESTIMATE: cfg_reg.initial_estimate      <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            sample_reg <= s_axis_tdata;
        end
    end

    // estimator state, restarted by a write of the initial estimate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estimate_reg  <= INIT_RST_TIME;
            deviation_reg <= '0;
        end
        else if (restart)
        begin
            estimate_reg  <= restart_time;
            deviation_reg <= '0;
        end
        else if (advance)
        begin
            estimate_reg  <= new_estimate;
            deviation_reg <= new_deviation;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_estimate_reg  <= FIELD_W'(new_estimate);
            out_deviation_reg <= FIELD_W'(new_deviation);
            out_timeout_reg   <= FIELD_W'(new_timeout);
        end
    end

endmodule

// File: rtl/core/rtte_update.sv
// ----------------------------------------------------------------------------
// rtte_update
// One estimator step: smoothed estimate, mean deviation and clamped timeout
// from a sample and the current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtte_update
    import rtte_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic [FIELD_W-1:0]    rtt_sample,
    input  logic [TIME_WIDTH-1:0] estimate,
    input  logic [TIME_WIDTH-1:0] deviation,
    input  rtte_cfg_t             cfg,
    output logic [TIME_WIDTH-1:0] new_estimate,
    output logic [TIME_WIDTH-1:0] new_deviation,
    output logic [TIME_WIDTH-1:0] new_timeout
);

    localparam int PROD_W = TIME_WIDTH + WEIGHT_W;
    localparam int HALF_W = TIME_WIDTH + 1;
    localparam int ACC_W  = TIME_WIDTH + 2;
    localparam int TO_W   = TIME_WIDTH + DEV_SHIFT + 1;
    localparam int FRAC_W = WEIGHT_W - 1;

    localparam logic [ACC_W-1:0] TIME_MAX_ACC = ACC_W'({TIME_WIDTH{1'b1}});

    logic [TIME_WIDTH-1:0] sample;
    logic [TIME_WIDTH-1:0] diff;
    logic [WEIGHT_W-1:0]   alpha;
    logic [WEIGHT_W-1:0]   beta;
    logic [PROD_W-1:0]     prod_sample;
    logic [PROD_W-1:0]     prod_estimate;
    logic [PROD_W-1:0]     prod_dev;
    logic [PROD_W-1:0]     prod_diff;
    logic [ACC_W-1:0]      est_sum;
    logic [ACC_W-1:0]      dev_sum;
    logic [TO_W-1:0]       to_sum;
    logic [TO_W-1:0]       floor_w;
    logic [TO_W-1:0]       ceil_w;
    logic [TO_W-1:0]       to_low;
    logic [TO_W-1:0]       to_clamped;

    always_comb
    begin
        sample = TIME_WIDTH'(sat_time(SAT_W'(rtt_sample), TIME_WIDTH));
        alpha  = sat_weight(cfg.sample_weight);
        beta   = sat_weight(cfg.deviation_keep_weight);
        diff   = (sample > estimate) ? (sample - estimate) : (estimate - sample);

        prod_sample   = PROD_W'(sample)    * PROD_W'(alpha);
        prod_estimate = PROD_W'(estimate)  * PROD_W'(Q_ONE - alpha);
        prod_dev      = PROD_W'(deviation) * PROD_W'(beta);
        prod_diff     = PROD_W'(diff)      * PROD_W'(Q_ONE - beta);

        // each product truncated on its own before the add
        est_sum = ACC_W'(prod_sample[PROD_W-1 -: HALF_W])
                + ACC_W'(prod_estimate[PROD_W-1 -: HALF_W]);
        dev_sum = ACC_W'(prod_dev[PROD_W-1 -: HALF_W])
                + ACC_W'(prod_diff[PROD_W-1 -: HALF_W]);

        new_estimate  = (est_sum > TIME_MAX_ACC) ? TIME_MAX_ACC[TIME_WIDTH-1:0]
                                                 : est_sum[TIME_WIDTH-1:0];
        new_deviation = (dev_sum > TIME_MAX_ACC) ? TIME_MAX_ACC[TIME_WIDTH-1:0]
                                                 : dev_sum[TIME_WIDTH-1:0];

        // full-width sum: anything past the time range lands on the ceiling
        to_sum  = TO_W'(new_estimate) + (TO_W'(new_deviation) << DEV_SHIFT);
        floor_w = TO_W'(sat_time(SAT_W'(cfg.timeout_floor), TIME_WIDTH));
        ceil_w  = TO_W'(sat_time(SAT_W'(cfg.timeout_ceiling), TIME_WIDTH));

        to_low     = (to_sum < floor_w) ? floor_w : to_sum;
        to_clamped = (to_low > ceil_w) ? ceil_w : to_low;
        new_timeout = to_clamped[TIME_WIDTH-1:0];
    end

    // FRAC_W documents the Q1.16 point used by the part-selects above
    if (FRAC_W != 16)
    begin : g_frac_check
        $error("weight format must be Q1.16");
    end

endmodule
